### rtl/skipstate_lfsr_keystream_macros.svh
// Assertion macros shared by the keystream generator modules.
`ifndef SKIPSTATE_LFSR_KEYSTREAM_MACROS_SVH
`define SKIPSTATE_LFSR_KEYSTREAM_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKLK_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sklk check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define SKLK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sklk check failed one cycle later");

`endif

### rtl/sklk_pkg.sv
`timescale 1ns / 1ps

package sklk_pkg;

   localparam int NUM_LFSR   = 8;
   localparam int LFSR_W     = 32;
   localparam int BYTE_W     = 8;
   localparam int PERM_DEPTH = 256;
   localparam int SEL_W      = $clog2(NUM_LFSR);

   // Operation codes carried by an input item.
   typedef enum logic [1:0] {
      OP_SEED     = 2'd0,
      OP_SHUFFLE  = 2'd1,
      OP_GENERATE = 2'd2,
      OP_IDENTITY = 2'd3
   } op_type;

   // Feedback taps and the bit set by a feedback step, one per register.
   localparam logic [LFSR_W-1:0] TAP_MASK [NUM_LFSR] = '{
      32'h8000_0057, 32'h2000_0029, 32'h4000_1000, 32'h0004_0013,
      32'h0001_0010, 32'h0000_100D, 32'h8000_0047, 32'h0040_0010
   };
   localparam logic [LFSR_W-1:0] TOP_MASK [NUM_LFSR] = '{
      32'h8000_0000, 32'h2000_0000, 32'h4000_0000, 32'h0004_0000,
      32'h0001_0000, 32'h0000_1000, 32'h8000_0000, 32'h0040_0000
   };

   // Control from the sequencer to the register bank.
   typedef struct packed {
      logic              load;
      logic              step;
      logic              gen;
      logic [SEL_W-1:0]  sel;
      logic [LFSR_W-1:0] seed;
   } lfsr_ctrl_type;

   // Control from the sequencer to the permutation store.
   typedef struct packed {
      logic              rd_en;
      logic [BYTE_W-1:0] rd_addr;
      logic              wr_en;
      logic [BYTE_W-1:0] wr_addr;
      logic [BYTE_W-1:0] wr_data;
      logic              clear;
   } perm_ctrl_type;

   // One clock of register idx: returns {output bit, next register value}.
   function automatic logic [LFSR_W:0] lfsr_clock(input logic [LFSR_W-1:0] r,
                                                 input logic [SEL_W-1:0] idx);
      logic [LFSR_W-1:0] cur;
      logic [LFSR_W-1:0] nxt;
      cur = (r == '0) ? '1 : r;
      if (cur[0]) begin
         nxt = ((cur ^ TAP_MASK[idx]) >> 1) | TOP_MASK[idx];
      end else begin
         nxt = cur >> 1;
      end
      return {cur[0], nxt};
   endfunction

endpackage

### rtl/skipstate_lfsr_keystream.sv
`timescale 1ns / 1ps
`include "skipstate_lfsr_keystream_macros.svh"

// Keystream generator: eight Galois LFSRs held in flip-flops and a keyed
// 256-byte permutation held in a RAM with a registered read, driven by a
// small sequencer that takes one item at a time. A generate item steps all
// eight LFSRs when taken; the permutation RAM read lands in ST_GEN_OUT, where
// the byte waits while the result register is full. A seed item loads its
// register when taken, then runs any pre-clocks in ST_SEED_RUN, one pre-clock
// per cycle. A shuffle item makes two dependent RAM reads, then the two swap
// writes through the single write port. A reset of the permutation is
// immediate, since per-entry valid bits make every entry read as its own
// index at once; there is no clearing pass after reset. The result register
// lets a new item be taken while a byte waits.
module skipstate_lfsr_keystream
   import sklk_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_operation,
   input  logic [2:0]        req_lfsr_select,
   input  logic [31:0]       req_seed_value,
   input  logic [7:0]        req_preclock_count,
   input  logic [7:0]        req_key_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_keystream_byte
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED_RUN,
      ST_SHUF_ACC,
      ST_SHUF_SWAP,
      ST_SHUF_FIN,
      ST_GEN_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [7:0]        cnt_ff, cnt_in;
   logic [SEL_W-1:0]  sel_ff, sel_in;
   logic [BYTE_W-1:0] key_ff, key_in;
   logic [BYTE_W-1:0] hold_ff, hold_in;
   logic [BYTE_W-1:0] idx_ff, idx_in;
   logic [BYTE_W-1:0] acc_ff, acc_in;
   logic [BYTE_W-1:0] ctr_ff, ctr_in;
   logic [BYTE_W-1:0] prev_ff, prev_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;

   lfsr_ctrl_type       lfsr_ctrl;
   perm_ctrl_type       perm_ctrl;
   logic [NUM_LFSR-1:0] gen_bits;
   logic [BYTE_W-1:0]   perm_data;
   logic                accept;
   logic [BYTE_W-1:0]   acc_sum;
   logic                out_free;

   sklk_lfsr_bank u_lfsr (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (lfsr_ctrl),
      .prev_byte (prev_ff),
      .gen_bits  (gen_bits)
   );

   sklk_perm u_perm (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (perm_ctrl),
      .rd_data (perm_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign acc_sum   = BYTE_W'(acc_ff + perm_data + key_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Sequencer: next state, datapath registers and the control to both units.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sel_in       = sel_ff;
      key_in       = key_ff;
      hold_in      = hold_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      ctr_in       = ctr_ff;
      prev_in      = prev_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      lfsr_ctrl    = '{load: 1'b0, step: 1'b0, gen: 1'b0, sel: sel_ff, seed: req_seed_value};
      perm_ctrl    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (op_type'(req_operation))
                  OP_SEED: begin
                     lfsr_ctrl.load = 1'b1;
                     lfsr_ctrl.sel  = req_lfsr_select;
                     sel_in         = req_lfsr_select;
                     cnt_in         = req_preclock_count;
                     if (req_preclock_count != '0) begin
                        state_in = ST_SEED_RUN;
                     end
                  end
                  OP_SHUFFLE: begin
                     perm_ctrl.rd_en   = 1'b1;
                     perm_ctrl.rd_addr = idx_ff;
                     key_in            = req_key_byte;
                     state_in          = ST_SHUF_ACC;
                  end
                  OP_GENERATE: begin
                     lfsr_ctrl.gen     = 1'b1;
                     perm_ctrl.rd_en   = 1'b1;
                     perm_ctrl.rd_addr = ctr_ff ^ gen_bits;
                     ctr_in            = BYTE_W'(ctr_ff + 1'b1);
                     state_in          = ST_GEN_OUT;
                  end
                  OP_IDENTITY: begin
                     perm_ctrl.clear = 1'b1;
                     idx_in          = '0;
                     acc_in          = '0;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SEED_RUN: begin
            // One plain clock of the seeded register per cycle.
            lfsr_ctrl.step = 1'b1;
            cnt_in         = 8'(cnt_ff - 1'b1);
            if (cnt_ff == 8'd1) begin
               state_in = ST_IDLE;
            end
         end
         ST_SHUF_ACC: begin
            hold_in           = perm_data;
            acc_in            = acc_sum;
            perm_ctrl.rd_en   = 1'b1;
            perm_ctrl.rd_addr = acc_sum;
            state_in          = ST_SHUF_SWAP;
         end
         ST_SHUF_SWAP: begin
            perm_ctrl.wr_en   = 1'b1;
            perm_ctrl.wr_addr = idx_ff;
            perm_ctrl.wr_data = perm_data;
            state_in          = ST_SHUF_FIN;
         end
         ST_SHUF_FIN: begin
            perm_ctrl.wr_en   = 1'b1;
            perm_ctrl.wr_addr = acc_ff;
            perm_ctrl.wr_data = hold_ff;
            idx_in            = BYTE_W'(idx_ff + 1'b1);
            state_in          = ST_IDLE;
         end
         ST_GEN_OUT: begin
            // The RAM read data holds while the result register is full.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = perm_data;
               prev_in      = perm_data;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         acc_ff       <= '0;
         ctr_ff       <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         acc_ff       <= acc_in;
         ctr_ff       <= ctr_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sel_ff      <= sel_in;
      key_ff      <= key_in;
      hold_ff     <= hold_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_keystream_byte = rsp_byte_ff;

   `SKLK_ASSERT_NEXT(a_gen_to_out, clock, reset, accept && req_operation == OP_GENERATE, state_ff == ST_GEN_OUT)
   `SKLK_ASSERT_NEXT(a_prev_matches, clock, reset, state_ff == ST_GEN_OUT && out_free, rsp_valid_ff && prev_ff == rsp_byte_ff)
   `SKLK_ASSERT_SAME(a_seed_count, clock, reset, state_ff == ST_SEED_RUN, cnt_ff != '0)

endmodule

### rtl/sklk_ram.sv
`timescale 1ns / 1ps

module sklk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port; the read data holds
   // until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sklk_lfsr_bank.sv
`timescale 1ns / 1ps

module sklk_lfsr_bank
   import sklk_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  lfsr_ctrl_type       ctrl,
   input  logic [BYTE_W-1:0]   prev_byte,
   output logic [NUM_LFSR-1:0] gen_bits
);

   logic [LFSR_W-1:0] lfsr_ff [NUM_LFSR];
   logic [LFSR_W-1:0] lfsr_in [NUM_LFSR];

   // Each register has its own clock logic; a generate clocks it once, or
   // twice when its bit of the previous output byte was set.
   for (genvar i = 0; i < NUM_LFSR; i++) begin : g_lfsr
      logic [LFSR_W:0]   first;
      logic [LFSR_W-1:0] mid;
      logic [LFSR_W:0]   last;
      logic              hit;

      always_comb begin
         hit   = (ctrl.sel == SEL_W'(i));
         first = lfsr_clock(lfsr_ff[i], SEL_W'(i));
         mid   = prev_byte[i] ? first[LFSR_W-1:0] : lfsr_ff[i];
         last  = lfsr_clock(mid, SEL_W'(i));
         gen_bits[i] = last[LFSR_W];
         priority if (ctrl.load && hit) begin
            lfsr_in[i] = ctrl.seed;
         end else if (ctrl.step && hit) begin
            lfsr_in[i] = first[LFSR_W-1:0];
         end else if (ctrl.gen) begin
            lfsr_in[i] = last[LFSR_W-1:0];
         end else begin
            lfsr_in[i] = lfsr_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            lfsr_ff[i] <= '0;
         end else begin
            lfsr_ff[i] <= lfsr_in[i];
         end
      end
   end

endmodule

### rtl/sklk_perm.sv
`timescale 1ns / 1ps
`include "skipstate_lfsr_keystream_macros.svh"

module sklk_perm
   import sklk_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  perm_ctrl_type     ctrl,
   output logic [BYTE_W-1:0] rd_data
);

   logic [PERM_DEPTH-1:0] valid_ff;
   logic [PERM_DEPTH-1:0] valid_in;
   logic [BYTE_W-1:0]     rd_addr_ff;
   logic                  rd_valid_ff;
   logic [BYTE_W-1:0]     ram_q;

   sklk_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (PERM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctrl.wr_en),
      .wr_addr (ctrl.wr_addr),
      .wr_data (ctrl.wr_data),
      .rd_en   (ctrl.rd_en),
      .rd_addr (ctrl.rd_addr),
      .rd_data (ram_q)
   );

   // An entry that was not written since the last clear holds its own index.
   always_comb begin
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = '0;
      end else if (ctrl.wr_en) begin
         valid_in[ctrl.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Keep the address and its valid bit beside the read data.
   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_addr_ff  <= ctrl.rd_addr;
         rd_valid_ff <= valid_ff[ctrl.rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? ram_q : rd_addr_ff;

   `SKLK_ASSERT_SAME(a_rd_wr_apart, clock, reset, ctrl.rd_en, !ctrl.wr_en)
   `SKLK_ASSERT_SAME(a_clear_no_wr, clock, reset, ctrl.clear, !ctrl.wr_en && !ctrl.rd_en)
   `SKLK_ASSERT_NEXT(a_clear_done, clock, reset, ctrl.clear, valid_ff == '0)

endmodule

### verif/sklk_keystream_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the keystream generator, keeps its own copy of the
// LFSR bank and the byte permutation, and compares every keystream byte that
// leaves the block against the byte predicted for the oldest generate item.
module sklk_keystream_checker
   import sklk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [2:0]  req_lfsr_select,
   input  logic [31:0] req_seed_value,
   input  logic [7:0]  req_preclock_count,
   input  logic [7:0]  req_key_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_keystream_byte,
   output int          mismatch_count,
   output int          pending_count
);

   // Predicted state of the block.
   logic [31:0] lfsr_bank [8];
   logic [7:0]  sbox [256];
   logic [7:0]  swap_index;
   logic [7:0]  swap_sum;
   logic [7:0]  byte_counter;
   logic [7:0]  last_keystream;

   // Keystream bytes still owed by the block, oldest first.
   logic [7:0]  owed_bytes [$];
   int          errors;

   // Feedback taps of each register.
   function automatic logic [31:0] feedback_taps(input int n);
      case (n)
         0: return 32'h8000_0057;
         1: return 32'h2000_0029;
         2: return 32'h4000_1000;
         3: return 32'h0004_0013;
         4: return 32'h0001_0010;
         5: return 32'h0000_100D;
         6: return 32'h8000_0047;
         default: return 32'h0040_0010;
      endcase
   endfunction

   // Bit position that a feedback step sets in each register.
   function automatic int high_bit(input int n);
      case (n)
         0: return 31;
         1: return 29;
         2: return 30;
         3: return 18;
         4: return 16;
         5: return 12;
         6: return 31;
         default: return 22;
      endcase
   endfunction

   // One clock of register n: returns the output bit above the next value.
   // An all-zero register is first forced to all ones.
   function automatic logic [32:0] clock_register(input logic [31:0] value, input int n);
      logic [31:0] cur;
      cur = (value == 32'h0) ? 32'hFFFF_FFFF : value;
      if (cur[0]) begin
         return {1'b1, ((cur ^ feedback_taps(n)) >> 1) | (32'h1 << high_bit(n))};
      end
      return {1'b0, cur >> 1};
   endfunction

   always @(posedge clock) begin
      logic [32:0] stepped;
      logic [7:0]  mixed;
      logic [7:0]  held;
      logic [7:0]  wanted;
      int          k;
      if (reset) begin
         for (k = 0; k < 8; k++) begin
            lfsr_bank[k] = 32'h0;
         end
         for (k = 0; k < 256; k++) begin
            sbox[k] = k[7:0];
         end
         swap_index = 8'h0;
         swap_sum = 8'h0;
         byte_counter = 8'h0;
         last_keystream = 8'h0;
         owed_bytes.delete();
         errors = 0;
      end else begin
         // A result accepted now always belongs to an item taken earlier.
         if (rsp_valid && rsp_ready) begin
            if (owed_bytes.size() == 0) begin
               $display("%0t: keystream item with none owed, expected none, actual %02h",
                        $time, rsp_keystream_byte);
               errors++;
            end else begin
               wanted = owed_bytes.pop_front();
               if (rsp_keystream_byte !== wanted) begin
                  $display("%0t: keystream_byte mismatch, expected %02h, actual %02h",
                           $time, wanted, rsp_keystream_byte);
                  errors++;
               end
            end
         end

         if (req_valid && req_ready) begin
            case (op_type'(req_operation))
               // Load one register, then run its pre-clocks with the bits dropped.
               OP_SEED: begin
                  lfsr_bank[req_lfsr_select] = req_seed_value;
                  for (k = 0; k < int'(req_preclock_count); k++) begin
                     stepped = clock_register(lfsr_bank[req_lfsr_select],
                                              int'(req_lfsr_select));
                     lfsr_bank[req_lfsr_select] = stepped[31:0];
                  end
               end
               // One key-schedule step: advance the sum, swap two entries.
               OP_SHUFFLE: begin
                  swap_sum = swap_sum + sbox[swap_index] + req_key_byte;
                  held = sbox[swap_index];
                  sbox[swap_index] = sbox[swap_sum];
                  sbox[swap_sum] = held;
                  swap_index = swap_index + 8'h1;
               end
               // Each register steps once, or twice if its bit of the last byte
               // was set; the bits are mixed with the counter and substituted.
               OP_GENERATE: begin
                  mixed = byte_counter;
                  byte_counter = byte_counter + 8'h1;
                  for (k = 0; k < 8; k++) begin
                     if (last_keystream[k]) begin
                        stepped = clock_register(lfsr_bank[k], k);
                        lfsr_bank[k] = stepped[31:0];
                     end
                     stepped = clock_register(lfsr_bank[k], k);
                     lfsr_bank[k] = stepped[31:0];
                     mixed[k] = mixed[k] ^ stepped[32];
                  end
                  last_keystream = sbox[mixed];
                  owed_bytes.push_back(last_keystream);
               end
               // The table goes back to identity; registers and counter stay.
               OP_IDENTITY: begin
                  for (k = 0; k < 256; k++) begin
                     sbox[k] = k[7:0];
                  end
                  swap_index = 8'h0;
                  swap_sum = 8'h0;
               end
               default: begin
               end
            endcase
         end
      end
      mismatch_count <= errors;
      pending_count <= owed_bytes.size();
   end

endmodule

### verif/tb_skipstate_lfsr_keystream.sv
`timescale 1ns / 1ps

module tb_skipstate_lfsr_keystream;
   import sklk_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_TARGET  = 1250;
   localparam int CALM_ITEMS     = 150;
   localparam int SETTLE_CYCLES  = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = OP_GENERATE;
   logic [2:0]  req_lfsr_select = 3'h0;
   logic [31:0] req_seed_value = 32'h0;
   logic [7:0]  req_preclock_count = 8'h0;
   logic [7:0]  req_key_byte = 8'h0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic [7:0]  rsp_keystream_byte;

   int mismatch_count;
   int pending_count;
   int items_sent = 0;
   int gap_pct = 0;
   int stall_pct = 0;
   int stall_left = 0;
   int quiet_cycles = 0;

   skipstate_lfsr_keystream DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_lfsr_select    (req_lfsr_select),
      .req_seed_value     (req_seed_value),
      .req_preclock_count (req_preclock_count),
      .req_key_byte       (req_key_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_keystream_byte (rsp_keystream_byte)
   );

   sklk_keystream_checker checker_inst (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_lfsr_select    (req_lfsr_select),
      .req_seed_value     (req_seed_value),
      .req_preclock_count (req_preclock_count),
      .req_key_byte       (req_key_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_keystream_byte (rsp_keystream_byte),
      .mismatch_count     (mismatch_count),
      .pending_count      (pending_count)
   );

   // 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The result side drops ready for a burst, the rest of its length drawn into
   // stall_left; a burst is cut short once stalls are switched off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0 && stall_pct != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 5);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Ends the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("skipstate_lfsr_keystream regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Presents one item, after an optional idle burst, and waits until it is taken.
   task automatic send_item(input op_type op, input logic [2:0] sel, input logic [31:0] seed,
                            input logic [7:0] pre, input logic [7:0] key);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_lfsr_select <= sel;
      req_seed_value <= seed;
      req_preclock_count <= pre;
      req_key_byte <= key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // Holds the sender off until every owed keystream byte has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int          runs;
      int          choice;
      logic [31:0] seed;
      logic [7:0]  pre;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: generates from all-zero registers, the key byte extremes,
      // seeds of zero and all ones, the longest pre-clock run, identity reset.
      send_item(OP_GENERATE, 3'($urandom), $urandom, 8'($urandom), 8'($urandom));
      send_item(OP_GENERATE, 3'($urandom), $urandom, 8'($urandom), 8'($urandom));
      send_item(OP_SHUFFLE, 3'($urandom), $urandom, 8'($urandom), 8'hFF);
      send_item(OP_SHUFFLE, 3'($urandom), $urandom, 8'($urandom), 8'h00);
      send_item(OP_SHUFFLE, 3'($urandom), $urandom, 8'($urandom), 8'($urandom));
      send_item(OP_GENERATE, 3'($urandom), $urandom, 8'($urandom), 8'($urandom));
      send_item(OP_SEED, 3'd0, 32'hFFFF_FFFF, 8'hFF, 8'($urandom));
      send_item(OP_SEED, 3'd1, 32'h0, 8'h00, 8'($urandom));
      send_item(OP_SEED, 3'd2, 32'h0, 8'h01, 8'($urandom));
      for (int s = 3; s < 8; s++) begin
         send_item(OP_SEED, s[2:0], $urandom, 8'($urandom_range(0, 15)), 8'($urandom));
      end
      send_item(OP_GENERATE, 3'($urandom), $urandom, 8'($urandom), 8'($urandom));
      send_item(OP_GENERATE, 3'($urandom), $urandom, 8'($urandom), 8'($urandom));
      send_item(OP_IDENTITY, 3'($urandom), $urandom, 8'($urandom), 8'($urandom));
      send_item(OP_GENERATE, 3'($urandom), $urandom, 8'($urandom), 8'($urandom));
      send_item(OP_SEED, 3'd7, 32'h0, 8'h00, 8'h00);
      send_item(OP_GENERATE, 3'($urandom), $urandom, 8'($urandom), 8'($urandom));

      // Random part, in phases: an optional fresh table, a key schedule that
      // now and then runs past a full index wrap, some reseeding, and then a
      // keystream run with a little noise mixed in.
      while (items_sent < RANDOM_TARGET) begin
         choice = $urandom_range(0, 2);
         gap_pct = (choice == 0) ? 0 : ((choice == 1) ? 15 : 40);
         choice = $urandom_range(0, 2);
         stall_pct = (choice == 0) ? 0 : ((choice == 1) ? 10 : 30);
         if (items_sent < 40 || $urandom_range(0, 3) == 0) begin
            drain_results();
         end
         if ($urandom_range(0, 2) != 0) begin
            send_item(OP_IDENTITY, 3'($urandom), $urandom, 8'($urandom), 8'($urandom));
         end
         runs = ($urandom_range(0, 9) < 2) ? $urandom_range(256, 300) : $urandom_range(0, 40);
         repeat (runs) begin
            send_item(OP_SHUFFLE, 3'($urandom), $urandom, 8'($urandom), 8'($urandom));
         end
         repeat ($urandom_range(0, 8)) begin
            seed = ($urandom_range(0, 7) == 0) ? 32'h0 : $urandom;
            pre = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(200, 255))
                                               : 8'($urandom_range(0, 8));
            send_item(OP_SEED, 3'($urandom), seed, pre, 8'($urandom));
         end
         repeat ($urandom_range(10, 50)) begin
            if ($urandom_range(0, 19) < 16) begin
               send_item(OP_GENERATE, 3'($urandom), $urandom, 8'($urandom), 8'($urandom));
            end else begin
               send_item(op_type'($urandom_range(0, 3)), 3'($urandom), $urandom,
                         8'($urandom_range(0, 4)), 8'($urandom));
            end
         end
      end

      // Last stretch at full rate on both sides.
      gap_pct = 0;
      stall_pct = 0;
      repeat (CALM_ITEMS) begin
         choice = $urandom_range(0, 9);
         if (choice < 7) begin
            send_item(OP_GENERATE, 3'($urandom), $urandom, 8'($urandom), 8'($urandom));
         end else if (choice < 9) begin
            send_item(OP_SHUFFLE, 3'($urandom), $urandom, 8'($urandom), 8'($urandom));
         end else begin
            send_item(OP_SEED, 3'($urandom), $urandom, 8'($urandom_range(0, 4)),
                      8'($urandom));
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("skipstate_lfsr_keystream regression: pass");
      end else begin
         $display("skipstate_lfsr_keystream regression: fail");
      end
      $finish;
   end

endmodule
